// ===== hw/rtl/slot_ring_queue_controller_defines.svh =====
// Assertion macros shared by the slot ring queue controller RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SLOT_RING_QUEUE_CONTROLLER_DEFINES_SVH
`define SLOT_RING_QUEUE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srq_pkg.sv =====
// Shared types, widths and codes of the slot ring queue controller.
// Depends on nothing; used by the channel interfaces and the top level.
`default_nettype none

package srq_pkg;

  localparam int SLOT_COUNT    = 64;
  localparam int PTR_W         = $clog2(SLOT_COUNT);
  localparam int CNT_W         = $clog2(SLOT_COUNT + 1);
  localparam int LENGTH_BITS   = 16;
  localparam int HDR_W         = LENGTH_BITS + 1;
  localparam int PCT_W         = 7;
  localparam int MARK_W        = CNT_W + PCT_W;
  localparam int PERCENT_SCALE = 100;
  localparam int REQ_W         = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [HDR_W-1:0]       hdr_t;
  typedef logic [PCT_W-1:0]       pct_t;
  typedef logic [REQ_W-1:0]       req_code_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_OVERSIZE = 3'd4
  } status_t;

  localparam req_code_t REQ_ACQUIRE = 3'd0;
  localparam req_code_t REQ_PUBLISH = 3'd1;
  localparam req_code_t REQ_ABORT   = 3'd2;
  localparam req_code_t REQ_CONSUME = 3'd3;
  localparam req_code_t REQ_RELEASE = 3'd4;

  localparam cfg_idx_t CFG_FILL_LIMIT    = 3'd0;
  localparam cfg_idx_t CFG_SLOTS_IN_USE  = 3'd1;
  localparam cfg_idx_t CFG_PAYLOAD_CAP   = 3'd2;
  localparam cfg_idx_t CFG_LOW_MARK_D    = 3'd3;
  localparam cfg_idx_t CFG_LOW_MARK_E    = 3'd4;
  localparam cfg_idx_t CFG_DROP_OVERSIZE = 3'd5;

  localparam cnt_t FILL_LIMIT_RST   = cnt_t'(SLOT_COUNT);
  localparam cnt_t SLOTS_IN_USE_RST = cnt_t'(SLOT_COUNT);
  localparam len_t PAYLOAD_CAP_RST  = len_t'(60);

endpackage

`default_nettype wire

// ===== hw/rtl/srq_ifs.sv =====
// Valid/ready channel interfaces of the slot ring queue controller:
// request, result and configuration write. Depends on srq_pkg.
`default_nettype none

interface srq_req_if;
  import srq_pkg::*;
  logic      valid;
  logic      ready;
  req_code_t req_type;
  len_t      requested_length;
  ptr_t      slot_number;
  len_t      written_length;
  logic      cut_short_in;

  modport source (output valid, req_type, requested_length, slot_number,
                  written_length, cut_short_in, input ready);
  modport sink   (input valid, req_type, requested_length, slot_number,
                  written_length, cut_short_in, output ready);
endinterface

interface srq_rsp_if;
  import srq_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  ptr_t    granted_slot;
  len_t    stored_length;
  logic    cut_short;
  cnt_t    occupancy;
  logic    full_event;
  logic    low_d_event;
  logic    low_e_event;

  modport source (output valid, status, granted_slot, stored_length, cut_short,
                  occupancy, full_event, low_d_event, low_e_event, input ready);
  modport sink   (input valid, status, granted_slot, stored_length, cut_short,
                  occupancy, full_event, low_d_event, low_e_event, output ready);
endinterface

interface srq_cfg_if;
  import srq_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slot_ring_queue_controller.sv =====
// Slot ring queue controller top level; depends on srq_pkg, srq_ifs and the defines header.
// A request transfer puts its result in the output register at the edge of the transfer,
// visible on the result channel in the next cycle. Throughput: one request per cycle
// while the result channel is ready; the header memory is read at the next read pointer.
// Reset (synchronous, active low) clears pointers, counters, latches, configuration registers
// and the output valid to their defaults; header memory contents stay undefined until published.
`default_nettype none
`include "slot_ring_queue_controller_defines.svh"

module slot_ring_queue_controller (
  input  logic  clk,
  input  logic  rst_n,
  srq_cfg_if.sink   cfg_bus,
  srq_req_if.sink   in_bus,
  srq_rsp_if.source out_bus
);
  import srq_pkg::*;

  // Configuration registers.
  cnt_t fill_limit_r;
  cnt_t slots_in_use_r;
  len_t capacity_r;
  pct_t mark_d_r;
  pct_t mark_e_r;
  logic drop_oversize_r;

  // Queue control state and its next values.
  ptr_t wr_ptr_r,      wr_ptr_nxt;
  ptr_t rd_ptr_r,      rd_ptr_nxt;
  cnt_t fill_cnt_r,    fill_cnt_nxt;
  logic resv_pend_r,   resv_pend_nxt;
  len_t resv_len_r,    resv_len_nxt;
  logic rd_busy_r,     rd_busy_nxt;
  logic full_latch_r,  full_latch_nxt;

  // Header memory. rd_data_r always holds the header at rd_ptr_r: the read is
  // issued at the read pointer's next value, and a same-cycle write is forwarded.
  hdr_t hdr_mem [SLOT_COUNT];
  hdr_t rd_data_r;
  logic mem_we;
  hdr_t mem_wdata;

  // Output register.
  logic    out_valid_r;
  status_t out_status_r;
  ptr_t    out_slot_r;
  len_t    out_len_r;
  logic    out_cut_r;
  cnt_t    out_occ_r;
  logic    out_full_ev_r;
  logic    out_d_ev_r;
  logic    out_e_ev_r;

  // Result of the request being transferred in this cycle.
  status_t res_status;
  ptr_t    res_slot;
  len_t    res_len;
  logic    res_cut;
  logic    res_full_ev;
  logic    res_d_ev;
  logic    res_e_ev;

  logic in_fire;
  logic out_free;
  logic pub_ok;
  cnt_t eff_slots;
  cnt_t eff_limit;
  cnt_t fill_inc;
  cnt_t fill_dec;
  len_t pub_len;
  logic pub_trunc;
  logic [MARK_W-1:0] old_scaled;
  logic [MARK_W-1:0] new_scaled;
  logic [MARK_W-1:0] thr_d;
  logic [MARK_W-1:0] thr_e;
  logic old_below_d, new_below_d, old_below_e, new_below_e;

  // A pointer at or beyond the slot count wraps to zero on its next advance.
  function automatic ptr_t advance_ptr(input ptr_t p, input cnt_t slots);
    cnt_t n;
    n = cnt_t'(p) + 1'b1;
    return (n >= slots) ? '0 : ptr_t'(n);
  endfunction

  // The output register parts the two sides: a new request is taken whenever the
  // current result is absent or leaves in this same cycle. Neither the request nor
  // the configuration channel takes a transfer while reset is held.
  assign out_free     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = out_free && rst_n;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = rst_n;

  // Out-of-range slot count and fill limit are clamped into their useful range.
  always_comb begin
    eff_slots = slots_in_use_r;
    if (slots_in_use_r == '0) begin
      eff_slots = cnt_t'(1);
    end else if (slots_in_use_r > cnt_t'(SLOT_COUNT)) begin
      eff_slots = cnt_t'(SLOT_COUNT);
    end
    eff_limit = (fill_limit_r == '0) ? cnt_t'(1) : fill_limit_r;
    if (eff_limit > eff_slots) begin
      eff_limit = eff_slots;
    end
  end

  // Watermark comparisons: occupancy times one hundred against limit times percent.
  assign fill_inc   = fill_cnt_r + 1'b1;
  assign fill_dec   = (fill_cnt_r != '0) ? fill_cnt_r - 1'b1 : '0;
  assign old_scaled = MARK_W'(fill_cnt_r) * MARK_W'(PERCENT_SCALE);
  assign new_scaled = MARK_W'(fill_dec) * MARK_W'(PERCENT_SCALE);
  assign thr_d      = MARK_W'(eff_limit) * MARK_W'(mark_d_r);
  assign thr_e      = MARK_W'(eff_limit) * MARK_W'(mark_e_r);
  assign old_below_d = (mark_d_r != '0) && (old_scaled < thr_d);
  assign new_below_d = (mark_d_r != '0) && (new_scaled < thr_d);
  assign old_below_e = (mark_e_r != '0) && (old_scaled < thr_e);
  assign new_below_e = (mark_e_r != '0) && (new_scaled < thr_e);

  // Publish clamps the length to the capacity; clamping, an oversize reservation
  // or the producer's own mark sets the truncated bit.
  always_comb begin
    pub_len   = in_bus.written_length;
    pub_trunc = in_bus.cut_short_in || (resv_len_r > capacity_r);
    if (in_bus.written_length > capacity_r) begin
      pub_len   = capacity_r;
      pub_trunc = 1'b1;
    end
  end

  // Request decode. A failed request reports only its status and the occupancy.
  always_comb begin
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    fill_cnt_nxt   = fill_cnt_r;
    resv_pend_nxt  = resv_pend_r;
    resv_len_nxt   = resv_len_r;
    rd_busy_nxt    = rd_busy_r;
    full_latch_nxt = full_latch_r;
    res_status     = ST_OK;
    res_slot       = '0;
    res_len        = '0;
    res_cut        = 1'b0;
    res_full_ev    = 1'b0;
    res_d_ev       = 1'b0;
    res_e_ev       = 1'b0;
    pub_ok         = 1'b0;
    if (in_fire) begin
      case (in_bus.req_type)
        REQ_ACQUIRE: begin
          if (resv_pend_r) begin
            res_status = ST_INVALID;
          end else if (fill_cnt_r >= eff_limit) begin
            res_status = ST_FULL;
          end else if (drop_oversize_r && in_bus.requested_length != '0 &&
                       in_bus.requested_length > capacity_r) begin
            res_status = ST_OVERSIZE;
          end else begin
            resv_pend_nxt = 1'b1;
            resv_len_nxt  = in_bus.requested_length;
            res_slot      = wr_ptr_r;
            res_len       = capacity_r;
          end
        end
        REQ_PUBLISH: begin
          if (!resv_pend_r || in_bus.slot_number != wr_ptr_r) begin
            res_status = ST_INVALID;
          end else begin
            pub_ok        = 1'b1;
            wr_ptr_nxt    = advance_ptr(wr_ptr_r, eff_slots);
            fill_cnt_nxt  = fill_inc;
            resv_pend_nxt = 1'b0;
            resv_len_nxt  = '0;
            res_len       = pub_len;
            res_cut       = pub_trunc;
            // The full event fires once, then waits for the D watermark to rearm it.
            if (fill_inc >= eff_limit && !full_latch_r) begin
              full_latch_nxt = 1'b1;
              res_full_ev    = 1'b1;
            end
          end
        end
        REQ_ABORT: begin
          if (!resv_pend_r) begin
            res_status = ST_INVALID;
          end else begin
            resv_pend_nxt = 1'b0;
            resv_len_nxt  = '0;
          end
        end
        REQ_CONSUME: begin
          if (rd_busy_r) begin
            res_status = ST_INVALID;
          end else if (fill_cnt_r == '0) begin
            res_status = ST_EMPTY;
          end else begin
            rd_busy_nxt = 1'b1;
            res_slot    = rd_ptr_r;
            res_len     = rd_data_r[LENGTH_BITS-1:0];
            res_cut     = rd_data_r[LENGTH_BITS];
          end
        end
        REQ_RELEASE: begin
          if (!rd_busy_r || in_bus.slot_number != rd_ptr_r) begin
            res_status = ST_INVALID;
          end else begin
            rd_ptr_nxt   = advance_ptr(rd_ptr_r, eff_slots);
            fill_cnt_nxt = fill_dec;
            rd_busy_nxt  = 1'b0;
            // Any change of side at the D watermark rearms the full event.
            if (old_below_d != new_below_d) begin
              full_latch_nxt = 1'b0;
            end
            res_d_ev = !old_below_d && new_below_d;
            res_e_ev = !old_below_e && new_below_e;
          end
        end
        default: begin
          res_status = ST_INVALID;
        end
      endcase
    end
  end

  assign mem_we    = pub_ok;
  assign mem_wdata = {pub_trunc, pub_len};

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_limit_r    <= FILL_LIMIT_RST;
      slots_in_use_r  <= SLOTS_IN_USE_RST;
      capacity_r      <= PAYLOAD_CAP_RST;
      mark_d_r        <= '0;
      mark_e_r        <= '0;
      drop_oversize_r <= 1'b0;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        CFG_FILL_LIMIT:    fill_limit_r    <= cfg_bus.data[CNT_W-1:0];
        CFG_SLOTS_IN_USE:  slots_in_use_r  <= cfg_bus.data[CNT_W-1:0];
        CFG_PAYLOAD_CAP:   capacity_r      <= cfg_bus.data[LENGTH_BITS-1:0];
        CFG_LOW_MARK_D:    mark_d_r        <= cfg_bus.data[PCT_W-1:0];
        CFG_LOW_MARK_E:    mark_e_r        <= cfg_bus.data[PCT_W-1:0];
        CFG_DROP_OVERSIZE: drop_oversize_r <= cfg_bus.data[0];
        default: begin
        end
      endcase
    end
  end

  // Queue control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      fill_cnt_r   <= '0;
      resv_pend_r  <= 1'b0;
      resv_len_r   <= '0;
      rd_busy_r    <= 1'b0;
      full_latch_r <= 1'b0;
    end else begin
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      resv_pend_r  <= resv_pend_nxt;
      resv_len_r   <= resv_len_nxt;
      rd_busy_r    <= rd_busy_nxt;
      full_latch_r <= full_latch_nxt;
    end
  end

  // Header memory: one write port at the write pointer, one registered read port
  // addressed by the read pointer's next value.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[wr_ptr_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && wr_ptr_r == rd_ptr_nxt) begin
      rd_data_r <= mem_wdata;
    end else begin
      rd_data_r <= hdr_mem[rd_ptr_nxt];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r  <= res_status;
      out_slot_r    <= res_slot;
      out_len_r     <= res_len;
      out_cut_r     <= res_cut;
      out_occ_r     <= fill_cnt_nxt;
      out_full_ev_r <= res_full_ev;
      out_d_ev_r    <= res_d_ev;
      out_e_ev_r    <= res_e_ev;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.status        = out_status_r;
  assign out_bus.granted_slot  = out_slot_r;
  assign out_bus.stored_length = out_len_r;
  assign out_bus.cut_short     = out_cut_r;
  assign out_bus.occupancy     = out_occ_r;
  assign out_bus.full_event    = out_full_ev_r;
  assign out_bus.low_d_event   = out_d_ev_r;
  assign out_bus.low_e_event   = out_e_ev_r;

  // A successful publish adds exactly one slot to the occupancy.
  `SRQ_ASSERT_NXT(a_publish_count, clk, rst_n, pub_ok,
    fill_cnt_r == $past(fill_cnt_r) + 1'b1, "publish did not advance fill count")
  // A pending full event in the output register implies the latch is set.
  `SRQ_ASSERT_IMP(a_full_latched, clk, rst_n, out_valid_r && out_full_ev_r,
    full_latch_r, "full event reported without full latch")
  // A consumed slot is always counted in the occupancy until it is released.
  `SRQ_ASSERT_IMP(a_busy_occupied, clk, rst_n, rd_busy_r,
    fill_cnt_r != '0, "reader busy with zero occupancy")
  // A good consume returns the slot at the old read pointer and marks the reader busy.
  `SRQ_ASSERT_NXT(a_consume_slot, clk, rst_n,
    in_fire && in_bus.req_type == REQ_CONSUME && res_status == ST_OK,
    rd_busy_r && out_slot_r == $past(rd_ptr_r), "consume returned wrong slot")

endmodule

`default_nettype wire

// ===== verif/slot_ring_queue_controller_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the slot ring queue controller top level.
// Depends on srq_pkg, the srq channel interfaces and the controller RTL.

module slot_ring_queue_controller_tb;
  import srq_pkg::*;

  // One request as the producer or consumer hands it to the controller.
  typedef struct packed {
    req_code_t kind;
    len_t      want;
    ptr_t      slot;
    len_t      wlen;
    logic      cut;
  } ring_req_t;

  // One result of the controller, field for field as on the result channel.
  typedef struct packed {
    status_t status;
    ptr_t    slot;
    len_t    len;
    logic    cut;
    cnt_t    occ;
    logic    ev_full;
    logic    ev_d;
    logic    ev_e;
  } ring_rsp_t;

  // Cycles without any transfer on any channel before the run is abandoned.
  // The slowest correct run never comes near this: each side stalls about one
  // cycle in nine, and a long stall is vanishingly rare.
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n;

  srq_cfg_if cfg_bus ();
  srq_req_if in_bus ();
  srq_rsp_if out_bus ();

  slot_ring_queue_controller uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the configuration registers, as last written.
  int cfg_limit, cfg_slots, cfg_cap, cfg_mark_d, cfg_mark_e, cfg_drop;

  // Shadow copy of the controller state.
  ptr_t wr_ptr, rd_ptr;
  int   occ;
  bit   resv_open;
  int   resv_len;
  bit   consumer_holds;
  bit   full_fired;
  hdr_t hdr_mem [SLOT_COUNT];

  ring_rsp_t expected_results[$];
  int        mismatches;
  bit        steady_traffic;
  int        quiet_cycles;

  // Out-of-range register values are folded the way the controller folds them:
  // a slot count of 0 acts as 1 and saturates at the ring size, and the fill
  // limit is at least 1 and never above the slot count.
  function automatic int ring_slots();
    int s;
    s = cfg_slots;
    if (s == 0) s = 1;
    if (s > SLOT_COUNT) s = SLOT_COUNT;
    return s;
  endfunction

  function automatic int ring_limit();
    int l;
    l = cfg_limit;
    if (l == 0) l = 1;
    if (l > ring_slots()) l = ring_slots();
    return l;
  endfunction

  // A pointer that sits at or past the slot count (after the count shrank)
  // wraps to zero on its next step.
  function automatic ptr_t ring_next(input ptr_t p);
    int n;
    n = int'(p) + 1;
    return (n >= ring_slots()) ? ptr_t'(0) : ptr_t'(n);
  endfunction

  function automatic bit under_mark(input int count, input int pct);
    return pct != 0 && count * PERCENT_SCALE < ring_limit() * pct;
  endfunction

  // Works out the result of one accepted request and moves the shadow state on.
  function automatic ring_rsp_t predict_ring_result(input ring_req_t r);
    ring_rsp_t o;
    int        len, oldc, newc;
    logic      tr;
    bit        od, nd, oe, ne;
    hdr_t      h;
    o.status  = ST_OK;
    o.slot    = '0;
    o.len     = '0;
    o.cut     = 1'b0;
    o.ev_full = 1'b0;
    o.ev_d    = 1'b0;
    o.ev_e    = 1'b0;
    case (r.kind)
      REQ_ACQUIRE: begin
        if (resv_open) o.status = ST_INVALID;
        else if (occ >= ring_limit()) o.status = ST_FULL;
        else if (cfg_drop != 0 && r.want != 0 && int'(r.want) > cfg_cap)
          o.status = ST_OVERSIZE;
        else begin
          resv_open = 1'b1;
          resv_len  = r.want;
          o.slot    = wr_ptr;
          o.len     = len_t'(cfg_cap);
        end
      end
      REQ_PUBLISH: begin
        if (!resv_open || r.slot != wr_ptr) o.status = ST_INVALID;
        else begin
          len = r.wlen;
          tr  = r.cut;
          if (len > cfg_cap) begin
            len = cfg_cap;
            tr  = 1'b1;
          end
          // A reservation that announced more than fits is truncated as well.
          if (resv_len > cfg_cap) tr = 1'b1;
          hdr_mem[wr_ptr] = {tr, len_t'(len)};
          wr_ptr    = ring_next(wr_ptr);
          occ       = occ + 1;
          resv_open = 1'b0;
          resv_len  = 0;
          o.len     = len_t'(len);
          o.cut     = tr;
          if (occ >= ring_limit() && !full_fired) begin
            full_fired = 1'b1;
            o.ev_full  = 1'b1;
          end
        end
      end
      REQ_ABORT: begin
        if (!resv_open) o.status = ST_INVALID;
        else begin
          resv_open = 1'b0;
          resv_len  = 0;
        end
      end
      REQ_CONSUME: begin
        if (consumer_holds) o.status = ST_INVALID;
        else if (occ == 0) o.status = ST_EMPTY;
        else begin
          h = hdr_mem[rd_ptr];
          consumer_holds = 1'b1;
          o.slot = rd_ptr;
          o.len  = h[LENGTH_BITS-1:0];
          o.cut  = h[LENGTH_BITS];
        end
      end
      REQ_RELEASE: begin
        if (!consumer_holds || r.slot != rd_ptr) o.status = ST_INVALID;
        else begin
          oldc = occ;
          newc = (oldc > 0) ? oldc - 1 : 0;
          rd_ptr = ring_next(rd_ptr);
          occ = newc;
          consumer_holds = 1'b0;
          // Any crossing of the D mark, either way, rearms the full event.
          od = under_mark(oldc, cfg_mark_d);
          nd = under_mark(newc, cfg_mark_d);
          if (od != nd) full_fired = 1'b0;
          if (!od && nd) o.ev_d = 1'b1;
          oe = under_mark(oldc, cfg_mark_e);
          ne = under_mark(newc, cfg_mark_e);
          if (!oe && ne) o.ev_e = 1'b1;
        end
      end
      default: o.status = ST_INVALID;
    endcase
    o.occ = cnt_t'(occ);
    return o;
  endfunction

  function automatic ring_req_t make_req(input req_code_t k, input int want = 0,
                                         input int slot = 0, input int wlen = 0,
                                         input bit cut = 1'b0);
    ring_req_t r;
    r.kind = k;
    r.want = len_t'(want);
    r.slot = ptr_t'(slot);
    r.wlen = len_t'(wlen);
    r.cut  = cut;
    return r;
  endfunction

  // Lengths cluster where the behavior changes: near zero, around and below the
  // capacity, and now and then anywhere in the 16-bit range.
  function automatic int pick_length();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(15);
      1: begin
        v = cfg_cap + int'($urandom_range(2)) - 1;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      2: v = $urandom_range(65535);
      default: v = $urandom_range(cfg_cap);
    endcase
    return v;
  endfunction

  // A request a correct producer or consumer would issue next. The producer
  // side is picked with probability producer_pct percent.
  function automatic ring_req_t pick_protocol_request(input int producer_pct);
    if ($urandom_range(99) < producer_pct) begin
      if (!resv_open) return make_req(REQ_ACQUIRE, pick_length());
      if ($urandom_range(99) < 85)
        return make_req(REQ_PUBLISH, 0, wr_ptr, pick_length(), $urandom_range(1));
      return make_req(REQ_ABORT);
    end
    if (!consumer_holds) return make_req(REQ_CONSUME);
    return make_req(REQ_RELEASE, 0, rd_ptr);
  endfunction

  // Any field pattern at all, unknown request codes included.
  function automatic ring_req_t pick_noise_request();
    return make_req(req_code_t'($urandom_range(7)), pick_length(),
                    $urandom_range(63), pick_length(), $urandom_range(1));
  endfunction

  // Presents one request, holding valid across back-to-back transfers, and
  // records the expected result at the edge where the transfer happens.
  task automatic send_request(input ring_req_t r);
    @(negedge clk);
    while (!steady_traffic && $urandom_range(99) < 11) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.req_type         = r.kind;
    in_bus.requested_length = r.want;
    in_bus.slot_number      = r.slot;
    in_bus.written_length   = r.wlen;
    in_bus.cut_short_in     = r.cut;
    in_bus.valid            = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    expected_results.push_back(predict_ring_result(r));
  endtask

  // Drops valid and waits until every outstanding result has been seen.
  task automatic hold_requests_until_drained();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Register writes only happen with the request side quiet and nothing owed.
  task automatic write_register(input cfg_idx_t idx, input int unsigned value);
    hold_requests_until_drained();
    @(negedge clk);
    cfg_bus.index = idx;
    cfg_bus.data  = cfg_data_t'(value);
    cfg_bus.valid = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_FILL_LIMIT:    cfg_limit  = value & 'h7F;
      CFG_SLOTS_IN_USE:  cfg_slots  = value & 'h7F;
      CFG_PAYLOAD_CAP:   cfg_cap    = value & 'hFFFF;
      CFG_LOW_MARK_D:    cfg_mark_d = value & 'h7F;
      CFG_LOW_MARK_E:    cfg_mark_e = value & 'h7F;
      CFG_DROP_OVERSIZE: cfg_drop   = value & 'h1;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic apply_settings(input int limit, input int slots, input int cap,
                                input int mark_d, input int mark_e, input int drop);
    write_register(CFG_FILL_LIMIT, limit);
    write_register(CFG_SLOTS_IN_USE, slots);
    write_register(CFG_PAYLOAD_CAP, cap);
    write_register(CFG_LOW_MARK_D, mark_d);
    write_register(CFG_LOW_MARK_E, mark_e);
    write_register(CFG_DROP_OVERSIZE, drop);
  endtask

  // Cancels any reservation and hands back every queued slot, so the ring is
  // empty with both pointers equal. The slot count may only change in this
  // state; otherwise a consume could land on a header that was never written.
  task automatic empty_ring();
    if (resv_open) send_request(make_req(REQ_ABORT));
    if (consumer_holds) send_request(make_req(REQ_RELEASE, 0, rd_ptr));
    while (occ > 0) begin
      send_request(make_req(REQ_CONSUME));
      send_request(make_req(REQ_RELEASE, 0, rd_ptr));
    end
    hold_requests_until_drained();
  endtask

  // Every request kind, every rejection but a full ring, clamping and truncation,
  // under the reset configuration and then with a zero capacity and the drop policy.
  task automatic test_request_corners();
    send_request(make_req(REQ_CONSUME));
    send_request(make_req(REQ_RELEASE, 0, rd_ptr));
    send_request(make_req(REQ_PUBLISH, 0, wr_ptr, 5));
    send_request(make_req(REQ_ABORT));
    for (int k = 1; k <= 3; k++)
      send_request(make_req(req_code_t'(REQ_RELEASE + k), 65535, 63, 65535, 1'b1));
    send_request(make_req(REQ_ACQUIRE, 65535));
    send_request(make_req(REQ_ACQUIRE, 1));
    send_request(make_req(REQ_PUBLISH, 0, wr_ptr + 1'b1, 3));
    send_request(make_req(REQ_PUBLISH, 0, wr_ptr, 65535, 1'b0));
    send_request(make_req(REQ_ACQUIRE, 10));
    send_request(make_req(REQ_ABORT));
    send_request(make_req(REQ_ACQUIRE, 0));
    send_request(make_req(REQ_PUBLISH, 0, wr_ptr, 0, 1'b1));
    send_request(make_req(REQ_CONSUME));
    send_request(make_req(REQ_CONSUME));
    send_request(make_req(REQ_RELEASE, 0, rd_ptr + 1'b1));
    send_request(make_req(REQ_RELEASE, 0, rd_ptr));
    empty_ring();
    // With no capacity at all, every nonzero length is clamped to zero.
    apply_settings(64, 64, 0, 0, 0, 1);
    send_request(make_req(REQ_ACQUIRE, 1));
    send_request(make_req(REQ_ACQUIRE, 0));
    send_request(make_req(REQ_PUBLISH, 0, wr_ptr, 1, 1'b0));
    empty_ring();
  endtask

  // One stretch of mostly well-formed traffic under fixed settings. A fifth of
  // the requests are arbitrary patterns. pause_at, when not negative, is the
  // item at which the sender waits for every outstanding result.
  task automatic run_traffic_phase(input int limit, input int slots, input int cap,
                                   input int mark_d, input int mark_e,
                                   input int drop, input int producer_pct,
                                   input int items, input int pause_at);
    apply_settings(limit, slots, cap, mark_d, mark_e, drop);
    for (int i = 0; i < items; i++) begin
      if (i == pause_at) hold_requests_until_drained();
      if ($urandom_range(99) < 20) send_request(pick_noise_request());
      else send_request(pick_protocol_request(producer_pct));
    end
    empty_ring();
  endtask

  // Small rings to wrap the pointers often and to reach the full and low
  // watermark events, then the register extremes and out-of-range values.
  task automatic test_watermarks_and_limits();
    run_traffic_phase(4, 4, 100, 50, 25, 0, 55, 120, 60);
    run_traffic_phase(1, 1, 60, 100, 100, 1, 50, 100, -1);
    // Fill limit above the slot count and marks above 100 percent.
    run_traffic_phase(127, 100, 65535, 127, 127, 0, 60, 120, -1);
    run_traffic_phase(0, 0, 1, 1, 1, 1, 50, 100, -1);
    // E mark above D mark, limit below the slot count.
    run_traffic_phase(8, 12, 30, 20, 80, 1, 60, 120, -1);
  endtask

  // A full ring of 64 slots driven to its limit with both sides never idling.
  task automatic test_full_ring_back_to_back();
    steady_traffic = 1'b1;
    run_traffic_phase(64, 64, 65535, 100, 50, 0, 85, 250, -1);
    steady_traffic = 1'b0;
  endtask

  // Random settings, all on small rings. Writes to the unused register
  // indexes must leave the configuration alone.
  task automatic test_random_settings();
    int slots, mark_d;
    write_register(CFG_DROP_OVERSIZE + 1'b1, 'hFFFF);
    write_register(CFG_DROP_OVERSIZE + 2'd2, 'hFFFF);
    for (int p = 0; p < 4; p++) begin
      slots  = $urandom_range(1, 16);
      mark_d = $urandom_range(100);
      run_traffic_phase($urandom_range(slots + 2), slots, $urandom_range(200),
                        mark_d, $urandom_range(mark_d), $urandom_range(1),
                        $urandom_range(45, 65), 110, -1);
    end
  endtask

  // Receiver side: stalls about one cycle in nine, except during steady runs.
  always @(negedge clk) begin
    out_bus.ready <= steady_traffic || ($urandom_range(99) >= 11);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Compares every result transfer with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    ring_rsp_t e;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing outstanding, status %0d",
                 $time, out_bus.status);
      end else begin
        e = expected_results.pop_front();
        check_field("status", e.status, out_bus.status);
        check_field("granted_slot", e.slot, out_bus.granted_slot);
        check_field("stored_length", e.len, out_bus.stored_length);
        check_field("cut_short", e.cut, out_bus.cut_short);
        check_field("occupancy", e.occ, out_bus.occupancy);
        check_field("full_event", e.ev_full, out_bus.full_event);
        check_field("low_d_event", e.ev_d, out_bus.low_d_event);
        check_field("low_e_event", e.ev_e, out_bus.low_e_event);
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on any channel means the
  // controller has hung.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("slot_ring_queue_controller_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n                   = 1'b0;
    in_bus.valid            = 1'b0;
    in_bus.req_type         = REQ_ACQUIRE;
    in_bus.requested_length = '0;
    in_bus.slot_number      = '0;
    in_bus.written_length   = '0;
    in_bus.cut_short_in     = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = CFG_FILL_LIMIT;
    cfg_bus.data            = '0;
    out_bus.ready           = 1'b0;
    quiet_cycles            = 0;
    mismatches              = 0;
    steady_traffic          = 1'b0;
    // Register and state values after reset.
    cfg_limit      = FILL_LIMIT_RST;
    cfg_slots      = SLOTS_IN_USE_RST;
    cfg_cap        = PAYLOAD_CAP_RST;
    cfg_mark_d     = 0;
    cfg_mark_e     = 0;
    cfg_drop       = 0;
    wr_ptr         = '0;
    rd_ptr         = '0;
    occ            = 0;
    resv_open      = 1'b0;
    resv_len       = 0;
    consumer_holds = 1'b0;
    full_fired     = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_request_corners();
    test_watermarks_and_limits();
    test_full_ring_back_to_back();
    test_random_settings();

    // Once every outstanding result is seen, the bench waits on to catch stray transfers.
    hold_requests_until_drained();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    if (mismatches == 0)
      $display("slot_ring_queue_controller_tb OK");
    else
      $display("slot_ring_queue_controller_tb NOT OK");
    $finish;
  end

endmodule
